// ----- rtl/wgen_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgen_pkg: shared types and constants of the waveform generator
// Register map, waveform codes, pipeline records and the sine table builder.
// ----------------------------------------------------------------------------
package wgen_pkg;

  localparam int unsigned SINE_ENTRIES = 1024;
  localparam int unsigned MID_DEPTH    = 2;
  localparam int unsigned OUT_DEPTH    = 4;
  localparam int unsigned CFG_IDX_W    = 4;

  localparam logic [31:0] RST_FREQ_STEP   = 32'd429496730;
  localparam logic [31:0] RST_PHASE_OFF   = 32'd0;
  localparam logic [31:0] RST_AMPLITUDE   = 32'd65536;
  localparam logic [31:0] RST_DC_OFFSET   = 32'd0;
  localparam logic [31:0] RST_PULSE_WIDTH = 32'd429496730;
  localparam logic [31:0] RST_PULSE_HIGH  = 32'd65536;
  localparam logic [31:0] RST_PULSE_LOW   = 32'd0;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;

  // triangle: |p - half turn| - quarter turn
  localparam logic signed [32:0] TRI_CENTER  = 33'sh0_8000_0000;
  localparam logic signed [32:0] TRI_QUARTER = 33'sh0_4000_0000;

  typedef enum logic [2:0] {
    WAVE_CONST    = 3'd0,
    WAVE_SINE     = 3'd1,
    WAVE_TRIANGLE = 3'd2,
    WAVE_SQUARE   = 3'd3,
    WAVE_RAMP     = 3'd4,
    WAVE_COUNTER  = 3'd5,
    WAVE_PULSE    = 3'd6
  } wave_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WAVE_TYPE   = 4'd0,
    REG_FREQ_STEP   = 4'd1,
    REG_PHASE_OFF   = 4'd2,
    REG_AMPLITUDE   = 4'd3,
    REG_DC_OFFSET   = 4'd4,
    REG_PULSE_WIDTH = 4'd5,
    REG_PULSE_HIGH  = 4'd6,
    REG_PULSE_LOW   = 4'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SH_0  = 2'd0,
    SH_15 = 2'd1,
    SH_30 = 2'd2,
    SH_32 = 2'd3
  } shift_e;

  typedef struct packed {
    logic [2:0]         wave_type;
    logic [31:0]        freq_step;
    logic [31:0]        phase_offset;
    logic signed [31:0] amplitude;
    logic signed [31:0] dc_offset;
    logic [31:0]        pulse_width_frac;
    logic signed [31:0] hi_level;
    logic signed [31:0] lo_level;
  } cfg_t;

  // request from the front: classified wave, phase, accumulator, counter
  typedef struct packed {
    wave_e       wave;
    logic [31:0] phase;
    logic [31:0] acc;
    logic [31:0] cnt;
  } mid_t;

  typedef struct packed {
    logic signed [31:0] sample;
    logic [31:0]        seq;
    logic               sat;
  } out_t;

  // Q1.15 sine, scaled by 32767, of a phase in turns * 2^32
  function automatic logic signed [15:0] sine_q15(input logic [31:0] ph);
    logic [1:0]         quad;
    logic [63:0]        r;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        mag;
    logic [15:0]        m16;
    logic signed [63:0] sum;
    quad = ph[31:30];
    r = {34'd0, ph[29:0]};
    if (quad[0]) begin
      r = ONE_Q30 - r;
    end
    x  = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k[0]) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    mag = (64'(sum) * 64'd32767 + 64'd536870912) >> 30;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    m16 = mag[15:0];
    return quad[1] ? $signed(16'd0 - m16) : $signed(m16);
  endfunction

endpackage

// ----- rtl/wgen_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgen_fifo: small register queue
// First-in first-out buffer with head read, fill count and full/empty flags.
// ----------------------------------------------------------------------------
module wgen_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [Width-1:0]           wdata_i,
  input  logic                       pop_i,
  output logic [Width-1:0]           rdata_o,
  output logic                       empty_o,
  output logic                       full_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign count_o = cnt_q;
  assign rdata_o = mem_q[rd_ptr_q];

  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- rtl/wgen_sine_rom.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgen_sine_rom: full-wave sine table
// Q1.15 entries built at elaboration, read with a registered output.
// ----------------------------------------------------------------------------
module wgen_sine_rom #(
  parameter int unsigned SineEntries = wgen_pkg::SINE_ENTRIES
) (
  input  logic                           clk_i,
  input  logic [$clog2(SineEntries)-1:0] addr_i,
  output logic signed [15:0]             data_o
);

  logic signed [15:0] rom [SineEntries];
  logic signed [15:0] data_q;

  for (genvar gi = 0; gi < SineEntries; gi++) begin : g_rom
    localparam logic [31:0] Ph = 32'((64'(gi) << 32) / SineEntries);
    assign rom[gi] = wgen_pkg::sine_q15(Ph);
  end

  always_ff @(posedge clk_i) begin
    data_q <= rom[addr_i];
  end

  assign data_o = data_q;

endmodule

// ----- rtl/wgen_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgen_front: sample request front end
// Accepts requests, keeps phase accumulator and sample counter, classifies.
// ----------------------------------------------------------------------------
module wgen_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  wgen_pkg::cfg_t  cfg_i,
  input  logic            push_i,
  input  logic            restart_i,
  input  logic [7:0]      skip_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output wgen_pkg::mid_t  rec_o
);

  logic [31:0] acc_q, acc_d;
  logic [31:0] cnt_q, cnt_d;
  logic [31:0] base_acc, base_cnt;
  logic [8:0]  steps;
  logic [40:0] step_prod;
  logic        acc_en;

  assign acc_en   = push_i & ~q_full_i;
  assign q_push_o = acc_en;

  // restart clears the state before this sample is formed
  assign base_acc  = restart_i ? '0 : acc_q;
  assign base_cnt  = restart_i ? '0 : cnt_q;
  assign steps     = 9'(skip_i) + 9'd1;
  assign step_prod = cfg_i.freq_step * steps;
  assign acc_d     = base_acc + step_prod[31:0];
  assign cnt_d     = base_cnt + 32'(steps);

  always_comb begin
    rec_o.wave  = wgen_pkg::wave_e'(cfg_i.wave_type);
    rec_o.phase = base_acc + cfg_i.phase_offset;
    rec_o.acc   = base_acc;
    rec_o.cnt   = base_cnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
    end else if (acc_en) begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
    end
  end

  a_restart_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_en && restart_i) |=> (cnt_q == 32'($past(skip_i)) + 32'd1))
    else $error("counter did not restart from the skip advance");

endmodule

// ----- rtl/wgen_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgen_back: sample computation back end
// Table read, gain multiply, offset add and saturation, then result queue.
// ----------------------------------------------------------------------------
module wgen_back #(
  parameter int unsigned SineEntries = wgen_pkg::SINE_ENTRIES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wgen_pkg::cfg_t     cfg_i,
  input  wgen_pkg::mid_t     head_i,
  input  logic               mid_empty_i,
  output logic               mid_pop_o,
  input  logic               pop_i,
  output logic               empty_o,
  output wgen_pkg::out_t     res_o
);

  localparam int unsigned IdxW    = $clog2(SineEntries);
  localparam int unsigned OutCntW = $clog2(wgen_pkg::OUT_DEPTH + 1);
  localparam logic signed [65:0] SatMax = 66'sh0_7FFF_FFFF;
  localparam logic signed [65:0] SatMin = -66'sh0_8000_0000;

  typedef struct packed {
    logic signed [32:0] op;
    logic               use_rom;
    logic               is_pulse;
    logic               pulse_hi;
    wgen_pkg::shift_e   shift;
    logic [31:0]        cnt;
  } s1_t;

  typedef struct packed {
    logic signed [64:0] prod;
    logic               is_pulse;
    logic               pulse_hi;
    wgen_pkg::shift_e   shift;
    logic [31:0]        cnt;
  } s2_t;

  logic               s1_v_q, s2_v_q;
  s1_t                s1_q, s1_d;
  s2_t                s2_q, s2_d;
  logic [32+IdxW:0]   idx_prod;
  logic [IdxW-1:0]    rom_addr;
  logic signed [15:0] rom_data;
  logic signed [32:0] tri_d, tri_abs;
  logic signed [32:0] opd;
  logic signed [64:0] term;
  logic signed [31:0] level;
  logic signed [65:0] sum;
  logic [OutCntW:0]   pending;
  logic [OutCntW-1:0] out_count;
  logic               out_full;
  logic               out_push;
  wgen_pkg::out_t     out_rec;

  // issue only when the result queue has room for everything in flight
  assign pending   = {1'b0, out_count} + (OutCntW+1)'(s1_v_q) + (OutCntW+1)'(s2_v_q);
  assign mid_pop_o = ~mid_empty_i & (pending < (OutCntW+1)'(wgen_pkg::OUT_DEPTH));

  // table index: floor(phase * entries / 2^32)
  assign idx_prod = {{(IdxW+1){1'b0}}, head_i.phase} * (33+IdxW)'(SineEntries);
  assign rom_addr = idx_prod[32 +: IdxW];

  wgen_sine_rom #(
    .SineEntries(SineEntries)
  ) u_rom (
    .clk_i (clk_i),
    .addr_i(rom_addr),
    .data_o(rom_data)
  );

  assign tri_d   = $signed({1'b0, head_i.phase}) - wgen_pkg::TRI_CENTER;
  assign tri_abs = tri_d[32] ? -tri_d : tri_d;

  always_comb begin
    s1_d.op       = '0;
    s1_d.use_rom  = 1'b0;
    s1_d.is_pulse = 1'b0;
    s1_d.pulse_hi = (head_i.phase <= cfg_i.pulse_width_frac);
    s1_d.shift    = wgen_pkg::SH_0;
    s1_d.cnt      = head_i.cnt;
    unique case (head_i.wave)
      wgen_pkg::WAVE_CONST: begin
        s1_d.op = 33'sd1;
      end
      wgen_pkg::WAVE_SINE: begin
        s1_d.use_rom = 1'b1;
        s1_d.shift   = wgen_pkg::SH_15;
      end
      wgen_pkg::WAVE_TRIANGLE: begin
        s1_d.op    = tri_abs - wgen_pkg::TRI_QUARTER;
        s1_d.shift = wgen_pkg::SH_30;
      end
      wgen_pkg::WAVE_SQUARE: begin
        s1_d.op = head_i.phase[31] ? 33'sd1 : -33'sd1;
      end
      wgen_pkg::WAVE_RAMP: begin
        s1_d.op    = $signed({1'b0, head_i.acc});
        s1_d.shift = wgen_pkg::SH_32;
      end
      wgen_pkg::WAVE_COUNTER: begin
        s1_d.op = $signed({1'b0, head_i.cnt});
      end
      wgen_pkg::WAVE_PULSE: begin
        s1_d.is_pulse = 1'b1;
      end
      default: begin
        // unused code: zero term, output is the offset alone
        s1_d.op = '0;
      end
    endcase
  end

  assign opd = s1_q.use_rom ? {{17{rom_data[15]}}, rom_data} : s1_q.op;

  always_comb begin
    s2_d.prod     = cfg_i.amplitude * opd;
    s2_d.is_pulse = s1_q.is_pulse;
    s2_d.pulse_hi = s1_q.pulse_hi;
    s2_d.shift    = s1_q.shift;
    s2_d.cnt      = s1_q.cnt;
  end

  always_comb begin
    unique case (s2_q.shift)
      wgen_pkg::SH_0:  term = s2_q.prod;
      wgen_pkg::SH_15: term = s2_q.prod >>> 15;
      wgen_pkg::SH_30: term = s2_q.prod >>> 30;
      wgen_pkg::SH_32: term = s2_q.prod >>> 32;
    endcase
    level = s2_q.pulse_hi ? cfg_i.hi_level : cfg_i.lo_level;
    if (s2_q.is_pulse) begin
      term = {{33{level[31]}}, level};
    end
    sum = {term[64], term} + {{34{cfg_i.dc_offset[31]}}, cfg_i.dc_offset};
    out_rec.seq = s2_q.cnt;
    priority if (sum > SatMax) begin
      out_rec.sample = SatMax[31:0];
      out_rec.sat    = 1'b1;
    end else if (sum < SatMin) begin
      out_rec.sample = SatMin[31:0];
      out_rec.sat    = 1'b1;
    end else begin
      out_rec.sample = sum[31:0];
      out_rec.sat    = 1'b0;
    end
  end

  assign out_push = s2_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= mid_pop_o;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
    s2_q <= s2_d;
  end

  wgen_fifo #(
    .Width($bits(wgen_pkg::out_t)),
    .Depth(wgen_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .wdata_i(out_rec),
    .pop_i  (pop_i),
    .rdata_o(res_o),
    .empty_o(empty_o),
    .full_o (out_full),
    .count_o(out_count)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> !out_full)
    else $error("result queue written while full");

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending <= (OutCntW+1)'(wgen_pkg::OUT_DEPTH))
    else $error("more requests in flight than result slots");

  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_push && out_rec.sat) |->
      (out_rec.sample == SatMax[31:0] || out_rec.sample == SatMin[31:0]))
    else $error("clipped sample not at a bound");

endmodule

// ----- rtl/waveform_generator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waveform_generator_core: one-channel function generator
// Config registers, front end, request queue and back end computation.
// ----------------------------------------------------------------------------
// Throughput: one sample per clock while the request queue has room and results
//   are popped; the phase and counter update in the front end is combinational.
// Path: a taken request passes the request queue, the table/operand stage and
//   the multiply stage, then its result is written to the result queue.
// Reset: asynchronous, active low; counter and accumulator clear, registers
//   take their defaults, queues empty. The sine table is constant.
// ----------------------------------------------------------------------------
module waveform_generator_core #(
  parameter int unsigned SineEntries = wgen_pkg::SINE_ENTRIES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wgen_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                   cfg_wdata_i,
  input  logic                          push,
  output logic                          full,
  input  logic                          restart_i,
  input  logic [7:0]                    skip_i,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [31:0]            sample_value_o,
  output logic [31:0]                   sequence_res_o,
  output logic                          saturated_o
);

  wgen_pkg::cfg_t cfg_q;
  wgen_pkg::mid_t front_rec, head_rec;
  wgen_pkg::out_t res;
  logic           q_push, q_pop, q_empty, q_full;
  logic [$clog2(wgen_pkg::MID_DEPTH+1)-1:0] q_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wave_type        <= wgen_pkg::WAVE_CONST;
      cfg_q.freq_step        <= wgen_pkg::RST_FREQ_STEP;
      cfg_q.phase_offset     <= wgen_pkg::RST_PHASE_OFF;
      cfg_q.amplitude        <= wgen_pkg::RST_AMPLITUDE;
      cfg_q.dc_offset        <= wgen_pkg::RST_DC_OFFSET;
      cfg_q.pulse_width_frac <= wgen_pkg::RST_PULSE_WIDTH;
      cfg_q.hi_level         <= wgen_pkg::RST_PULSE_HIGH;
      cfg_q.lo_level         <= wgen_pkg::RST_PULSE_LOW;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wgen_pkg::REG_WAVE_TYPE:   cfg_q.wave_type        <= cfg_wdata_i[2:0];
        wgen_pkg::REG_FREQ_STEP:   cfg_q.freq_step        <= cfg_wdata_i;
        wgen_pkg::REG_PHASE_OFF:   cfg_q.phase_offset     <= cfg_wdata_i;
        wgen_pkg::REG_AMPLITUDE:   cfg_q.amplitude        <= cfg_wdata_i;
        wgen_pkg::REG_DC_OFFSET:   cfg_q.dc_offset        <= cfg_wdata_i;
        wgen_pkg::REG_PULSE_WIDTH: cfg_q.pulse_width_frac <= cfg_wdata_i;
        wgen_pkg::REG_PULSE_HIGH:  cfg_q.hi_level         <= cfg_wdata_i;
        wgen_pkg::REG_PULSE_LOW:   cfg_q.lo_level         <= cfg_wdata_i;
        default: ; // drop writes beyond the register map
      endcase
    end
  end

  wgen_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .push_i   (push),
    .restart_i(restart_i),
    .skip_i   (skip_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .rec_o    (front_rec)
  );

  wgen_fifo #(
    .Width($bits(wgen_pkg::mid_t)),
    .Depth(wgen_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .wdata_i(front_rec),
    .pop_i  (q_pop),
    .rdata_o(head_rec),
    .empty_o(q_empty),
    .full_o (q_full),
    .count_o(q_count)
  );

  wgen_back #(
    .SineEntries(SineEntries)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .head_i     (head_rec),
    .mid_empty_i(q_empty),
    .mid_pop_o  (q_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .res_o      (res)
  );

  assign full           = q_full;
  assign sample_value_o = res.sample;
  assign sequence_res_o = res.seq;
  assign saturated_o    = res.sat;

  a_queue_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> (!q_empty && q_count == 2'(wgen_pkg::MID_DEPTH)))
    else $error("request queue flags disagree with its count");

endmodule

// ----- bench/tb_waveform_generator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_waveform_generator_core: regression bench of the function generator core
// Drives sample requests and register settings, keeps its own copy of the
// accumulator, counter and registers, and checks every result in order.
// ----------------------------------------------------------------------------
module tb_waveform_generator_core;
  import wgen_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS   = 850;
  localparam int unsigned DRAIN_CYCLES   = 16;
  localparam int unsigned MAX_REPORTS    = 30;

  localparam logic [2:0]           WAVE_UNUSED     = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 4'd8;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [31:0]          cfg_wdata_i = '0;
  logic                 push = 1'b0;
  logic                 full;
  logic                 restart_i = 1'b0;
  logic [7:0]           skip_i = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic signed [31:0]   sample_value_o;
  logic [31:0]          sequence_res_o;
  logic                 saturated_o;

  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int n_settings = 0;
  int idle_cycles = 0;

  waveform_generator_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .push          (push),
    .full          (full),
    .restart_i     (restart_i),
    .skip_i        (skip_i),
    .empty         (empty),
    .pop           (pop),
    .sample_value_o(sample_value_o),
    .sequence_res_o(sequence_res_o),
    .saturated_o   (saturated_o)
  );

  // Tracks the generator state and holds the samples still owed by the core.
  class sample_tracker;
    cfg_t               regs;
    logic [31:0]        cnt;
    logic [31:0]        acc;
    logic signed [15:0] sine_lut [SINE_ENTRIES];
    out_t               pending_samples [$];
    int                 errors;
    int                 n_noted;
    int                 n_checked;

    function new();
      logic [63:0] ph;
      regs.wave_type        = WAVE_CONST;
      regs.freq_step        = RST_FREQ_STEP;
      regs.phase_offset     = RST_PHASE_OFF;
      regs.amplitude        = RST_AMPLITUDE;
      regs.dc_offset        = RST_DC_OFFSET;
      regs.pulse_width_frac = RST_PULSE_WIDTH;
      regs.hi_level         = RST_PULSE_HIGH;
      regs.lo_level         = RST_PULSE_LOW;
      cnt = '0;
      acc = '0;
      errors = 0;
      n_noted = 0;
      n_checked = 0;
      for (int i = 0; i < SINE_ENTRIES; i++) begin
        ph = (64'(i) << 32) / 64'(SINE_ENTRIES);
        sine_lut[i] = q15_sine(ph[31:0]);
      end
    endfunction

    // quarter-wave Taylor series in Q30, folded by quadrant
    function logic signed [15:0] q15_sine(logic [31:0] ph);
      longint unsigned r;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned mag;
      longint          series;
      logic [15:0]     m;
      r = ph[29:0];
      if (ph[30]) begin
        r = ONE_Q30 - r;
      end
      x  = (r * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      t = x;
      series = x;
      for (int k = 1; k <= 7; k++) begin
        t = ((t * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if (k % 2) begin
          series = series - t;
        end else begin
          series = series + t;
        end
      end
      if (series < 0) begin
        series = 0;
      end
      mag = series;
      mag = (mag * 64'd32767 + 64'd536870912) >> 30;
      if (mag > 64'd32767) begin
        mag = 64'd32767;
      end
      m = mag[15:0];
      return ph[31] ? -$signed(m) : $signed(m);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        REG_WAVE_TYPE:   regs.wave_type        = data[2:0];
        REG_FREQ_STEP:   regs.freq_step        = data;
        REG_PHASE_OFF:   regs.phase_offset     = data;
        REG_AMPLITUDE:   regs.amplitude        = data;
        REG_DC_OFFSET:   regs.dc_offset        = data;
        REG_PULSE_WIDTH: regs.pulse_width_frac = data;
        REG_PULSE_HIGH:  regs.hi_level         = data;
        REG_PULSE_LOW:   regs.lo_level         = data;
        default: ;
      endcase
    endfunction

    // waveform term for the phase (accumulator or counter for ramp and counter), exact in 64 bits
    function longint wave_term(logic [31:0] p);
      longint      amp;
      longint      d;
      longint      u;
      logic [63:0] idx;
      amp = $signed(regs.amplitude);
      case (regs.wave_type)
        WAVE_CONST: wave_term = amp;
        WAVE_SINE: begin
          idx = (64'(p) * 64'(SINE_ENTRIES)) >> 32;
          if (idx >= 64'(SINE_ENTRIES)) begin
            idx = 64'(SINE_ENTRIES) - 64'd1;
          end
          wave_term = (amp * sine_lut[idx]) >>> 15;
        end
        WAVE_TRIANGLE: begin
          d = p;
          d = d - 64'sd2147483648;
          if (d < 0) begin
            d = -d;
          end
          wave_term = (amp * (d - 64'sd1073741824)) >>> 30;
        end
        WAVE_SQUARE: wave_term = (p < 32'h8000_0000) ? -amp : amp;
        WAVE_RAMP: begin
          u = acc;
          wave_term = (amp * u) >>> 32;
        end
        WAVE_COUNTER: begin
          u = cnt;
          wave_term = amp * u;
        end
        WAVE_PULSE: begin
          if (p <= regs.pulse_width_frac) begin
            wave_term = $signed(regs.hi_level);
          end else begin
            wave_term = $signed(regs.lo_level);
          end
        end
        default: wave_term = 0;
      endcase
    endfunction

    function void note_request(logic restart, logic [7:0] skip);
      out_t        want;
      longint      total;
      logic [31:0] steps;
      if (restart) begin
        cnt = '0;
        acc = '0;
      end
      total = wave_term(acc + regs.phase_offset) + $signed(regs.dc_offset);
      want.sat = 1'b0;
      if (total > 64'sd2147483647) begin
        total = 64'sd2147483647;
        want.sat = 1'b1;
      end else if (total < -64'sd2147483648) begin
        total = -64'sd2147483648;
        want.sat = 1'b1;
      end
      want.sample = total[31:0];
      want.seq = cnt;
      pending_samples.insert(pending_samples.size(), want);
      n_noted++;
      // advance by this period plus the missed ones, both wrap at 32 bits
      steps = 32'd1 + 32'(skip);
      cnt = cnt + steps;
      acc = acc + regs.freq_step * steps;
    endfunction

    function void mismatch(string field, longint want, longint got);
      errors++;
      if (errors <= MAX_REPORTS) begin
        $error("%s: expected %0d, actual %0d", field, want, got);
      end
    endfunction

    function void check_sample(logic signed [31:0] v, logic [31:0] seq, logic sat);
      out_t want;
      if (pending_samples.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $error("result with no request pending: sample_value %0d", v);
        end
        return;
      end
      want = pending_samples.pop_front();
      n_checked++;
      if (v !== want.sample) begin
        mismatch("sample_value", want.sample, v);
      end
      if (seq !== want.seq) begin
        mismatch("sequence_res", want.seq, seq);
      end
      if (sat !== want.sat) begin
        mismatch("saturated", want.sat, sat);
      end
    endfunction

    function int pending();
      return pending_samples.size();
    endfunction
  endclass

  sample_tracker tracker;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 0;
      6, 7, 8:          return $urandom_range(1, 3);
      default:          return $urandom_range(8, 40);
    endcase
  endfunction

  function automatic logic [31:0] rand_level();
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0: v = 32'h7FFF_FFFF;
      1: v = 32'h8000_0000;
      2, 3, 4: begin
        v = $urandom_range(0, 32'h0004_0000);
        if ($urandom_range(0, 1)) begin
          v = -v;
        end
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] rand_skip();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 8'd0;
      5, 6, 7:       return 8'($urandom_range(1, 7));
      default:       return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic cfg_t reset_cfg();
    cfg_t c;
    c.wave_type        = WAVE_CONST;
    c.freq_step        = RST_FREQ_STEP;
    c.phase_offset     = RST_PHASE_OFF;
    c.amplitude        = RST_AMPLITUDE;
    c.dc_offset        = RST_DC_OFFSET;
    c.pulse_width_frac = RST_PULSE_WIDTH;
    c.hi_level         = RST_PULSE_HIGH;
    c.lo_level         = RST_PULSE_LOW;
    return c;
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.wave_type = ($urandom_range(0, 15) == 0) ? WAVE_UNUSED : 3'($urandom_range(0, 6));
    case ($urandom_range(0, 3))
      0: c.freq_step = $urandom_range(0, 4095);
      1: c.freq_step = $urandom;
      2: c.freq_step = 32'hFFFF_F000 | $urandom_range(0, 4095);
      default: c.freq_step = 32'd1 << $urandom_range(0, 31);
    endcase
    c.phase_offset = $urandom_range(0, 1) ? $urandom : 32'd0;
    c.amplitude = rand_level();
    c.dc_offset = rand_level();
    case ($urandom_range(0, 3))
      0: c.pulse_width_frac = 32'd0;
      1: c.pulse_width_frac = 32'hFFFF_FFFF;
      default: c.pulse_width_frac = $urandom;
    endcase
    c.hi_level = rand_level();
    c.lo_level = rand_level();
    return c;
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    tracker.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  // write every register; the wave code carries random upper bits
  task automatic apply_cfg(input cfg_t c, input bit unmapped);
    logic [31:0]          wd;
    logic [CFG_IDX_W-1:0] ui;
    wd = $urandom;
    wd[2:0] = c.wave_type;
    cfg_write(REG_WAVE_TYPE, wd);
    cfg_write(REG_FREQ_STEP, c.freq_step);
    cfg_write(REG_PHASE_OFF, c.phase_offset);
    cfg_write(REG_AMPLITUDE, c.amplitude);
    cfg_write(REG_DC_OFFSET, c.dc_offset);
    cfg_write(REG_PULSE_WIDTH, c.pulse_width_frac);
    cfg_write(REG_PULSE_HIGH, c.hi_level);
    cfg_write(REG_PULSE_LOW, c.lo_level);
    if (unmapped) begin
      ui = REG_UNMAPPED_LO + CFG_IDX_W'($urandom_range(0, 7));
      cfg_write(ui, $urandom);
    end
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // enter and leave at a falling edge; push stays high for the next request
  task automatic send(input logic r, input logic [7:0] s);
    int g;
    g = tx_idle_en ? gap_len() : 0;
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    push <= 1'b1;
    restart_i <= r;
    skip_i <= s;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    tracker.note_request(r, s);
    @(negedge clk_i);
  endtask

  // hold the sender until the core has returned everything
  task automatic finish_phase();
    push <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      tracker.check_sample(sample_value_o, sequence_res_o, saturated_o);
    end
  end

  initial begin
    int stall;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_idle_en && stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
        if (rx_idle_en && $urandom_range(0, 3) == 0) begin
          stall = gap_len();
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("waveform_generator_core regression: fail");
      $finish;
    end
  end

  initial begin
    cfg_t c;
    int   n_rand;
    int   n_items;
    tracker = new();
    n_rand = 0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings, full skip, restart
    send(1'b0, 8'd0);
    send(1'b0, 8'hFF);
    send(1'b1, 8'd0);
    finish_phase();

    // sine at the quarter points, full scale; unmapped writes must not land
    c = reset_cfg();
    c.wave_type = WAVE_SINE;
    c.freq_step = 32'h4000_0000;
    c.amplitude = 32'h7FFF_FFFF;
    apply_cfg(c, 1'b1);
    send(1'b1, 8'd0);
    repeat (3) send(1'b0, 8'd0);
    finish_phase();

    // triangle with most negative gain against the top offset: clips high
    c = reset_cfg();
    c.wave_type = WAVE_TRIANGLE;
    c.freq_step = 32'h4000_0000;
    c.amplitude = 32'h8000_0000;
    c.dc_offset = 32'h7FFF_FFFF;
    apply_cfg(c, 1'b0);
    send(1'b1, 8'd0);
    repeat (2) send(1'b0, 8'd0);
    finish_phase();

    // square on either side of the half turn
    c = reset_cfg();
    c.wave_type = WAVE_SQUARE;
    c.freq_step = 32'd1;
    c.phase_offset = 32'h7FFF_FFFF;
    c.amplitude = 32'h7FFF_FFFF;
    c.dc_offset = 32'h8000_0000;
    apply_cfg(c, 1'b0);
    send(1'b1, 8'd0);
    send(1'b0, 8'd0);
    finish_phase();

    // ramp clipping low, accumulator wraps
    c = reset_cfg();
    c.wave_type = WAVE_RAMP;
    c.freq_step = 32'hFFFF_FFFF;
    c.amplitude = 32'h8000_0000;
    c.dc_offset = 32'h8000_0000;
    apply_cfg(c, 1'b0);
    send(1'b1, 8'd0);
    send(1'b0, 8'd1);
    send(1'b0, 8'd0);
    finish_phase();

    // counter at full gain
    c = reset_cfg();
    c.wave_type = WAVE_COUNTER;
    c.amplitude = 32'h7FFF_FFFF;
    c.dc_offset = 32'h7FFF_FFFF;
    apply_cfg(c, 1'b0);
    send(1'b1, 8'hFF);
    send(1'b0, 8'd0);
    finish_phase();

    // pulse edge at zero width
    c = reset_cfg();
    c.wave_type = WAVE_PULSE;
    c.freq_step = 32'd1;
    c.pulse_width_frac = 32'd0;
    c.hi_level = 32'h7FFF_FFFF;
    c.lo_level = 32'h8000_0000;
    apply_cfg(c, 1'b0);
    send(1'b1, 8'd0);
    send(1'b0, 8'd0);
    finish_phase();

    // unused wave code: only the offset reaches the output
    c = reset_cfg();
    c.wave_type = WAVE_UNUSED;
    c.dc_offset = 32'hFFFF_FFFB;
    apply_cfg(c, 1'b0);
    send(1'b0, 8'd0);
    send(1'b1, 8'd0);
    finish_phase();

    while (n_rand < RANDOM_ITEMS) begin
      c = random_cfg();
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      apply_cfg(c, $urandom_range(0, 3) == 0);
      n_items = $urandom_range(10, 60);
      for (int i = 0; i < n_items; i++) begin
        send($urandom_range(0, 31) == 0, rand_skip());
      end
      n_rand += n_items;
      finish_phase();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("covered %0d requests and %0d results over %0d register settings",
             tracker.n_noted, tracker.n_checked, n_settings);
    $display("with every wave code, clipping at both rails, restarts and skips up to 255");
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("waveform_generator_core regression: pass");
    end else begin
      $display("waveform_generator_core regression: fail");
    end
    $finish;
  end

endmodule
